@@ sv/thc_pkg.sv @@
// Shared widths, latencies, register codes and constant tables for the
// tilt-compensated heading pipeline. No dependencies.
`default_nettype none

package thc_pkg;

  // Fixed datapath widths
  localparam int BODY_W  = 33;  // body field, Q.14 counts
  localparam int PROD_W  = 49;  // body field times Q14 trig
  localparam int MX_W    = 64;  // horizontal components, Q42
  localparam int MAG_W   = 63;  // magnitudes of the horizontal components
  localparam int NORM_W  = 30;  // magnitudes after the common right shift
  localparam int SUM_W   = 61;  // sum of squares
  localparam int ROOT_W  = 31;  // integer square root
  localparam int NUM_W   = 45;  // divider numerator
  localparam int QUOT_W  = 15;  // divider quotient
  localparam int XY_W    = 34;  // CORDIC x and y, Q30
  localparam int Z_W     = 26;  // CORDIC angle, 2^-24 turn

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STAGES   = 31;
  localparam int DIV_STAGES    = 15;

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int TILT_LAT   = 8;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int TOTAL_LAT  = CORDIC_LAT + TILT_LAT + SQRT_STAGES + DIV_LAT + 1;

  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032874);
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef enum logic [2:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_GAIN_Z   = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic neg_x;   // mx negative
    logic pos_y;   // my positive, heading y goes negative
    logic zero;    // horizontal field exactly zero
  } flags_t;

  typedef struct packed {
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    flags_t            flags;
  } side_t;

  // arctan(2^-i) in 2^-24 turn
  function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(2097152);
      1:       v = Z_W'(1238021);
      2:       v = Z_W'(654136);
      3:       v = Z_W'(332050);
      4:       v = Z_W'(166669);
      5:       v = Z_W'(83416);
      6:       v = Z_W'(41718);
      7:       v = Z_W'(20860);
      8:       v = Z_W'(10430);
      9:       v = Z_W'(5215);
      10:      v = Z_W'(2608);
      11:      v = Z_W'(1304);
      12:      v = Z_W'(652);
      13:      v = Z_W'(326);
      14:      v = Z_W'(163);
      15:      v = Z_W'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/tilt_compensated_heading_unit.sv @@
// Tilt-compensated heading unit: each accepted start yields one out_valid strobe;
// one word accepted every cycle, so busy is never raised.
// The 16-stage CORDIC, the tilt rotation, the 31-stage square root and the
// 15-stage divider run in series. Results cannot be stalled by the receiver.
// rst_n (synchronous, active low) empties the pipeline and restores unity gains
// and zero offsets; configuration words are taken at any cycle.
`default_nettype none

module tilt_compensated_heading_unit (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic signed [15:0] in_raw_z,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  // result channel
  output logic               out_valid,
  output logic signed [15:0] out_heading_x,
  output logic signed [15:0] out_heading_y,
  output logic               out_zero_field,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import thc_pkg::*;

  // Calibration registers
  logic [15:0]        gain_x_r, gain_y_r, gain_z_r;
  logic signed [15:0] offset_x_r, offset_y_r, offset_z_r;

  logic               accept;
  logic signed [16:0] sx, sy, sz;
  logic signed [16:0] ry_e, rz_e;
  logic signed [BODY_W-1:0] bx_dly_r [0:CORDIC_LAT-1];
  logic signed [BODY_W-1:0] by_dly_r [0:CORDIC_LAT-1];
  logic signed [BODY_W-1:0] bz_dly_r [0:CORDIC_LAT-1];

  logic               roll_v, pitch_v;
  logic signed [15:0] sr, cr, sp, cp;

  logic               tilt_v;
  logic [SUM_W-1:0]   sumsq;
  side_t              tilt_side;

  logic               root_v;
  logic [ROOT_W-1:0]  root;
  side_t              root_side;

  logic               div_v;
  logic [QUOT_W-1:0]  qx, qy;
  flags_t             div_flags;

  logic [QUOT_W-1:0]  hx_c, hy_c;
  logic signed [15:0] hx_s, hy_s;
  logic               out_valid_r;
  logic signed [15:0] heading_x_r, heading_y_r;
  logic               zero_field_r;

  // Pipeline never stalls: a word enters on any cycle
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r   <= ONE_Q14;
      gain_y_r   <= ONE_Q14;
      gain_z_r   <= ONE_Q14;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_X:   gain_x_r   <= cfg_data;
        REG_GAIN_Y:   gain_y_r   <= cfg_data;
        REG_GAIN_Z:   gain_z_r   <= cfg_data;
        REG_OFFSET_X: offset_x_r <= signed'(cfg_data);
        REG_OFFSET_Y: offset_y_r <= signed'(cfg_data);
        REG_OFFSET_Z: offset_z_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Body field: s * gain + offset * 2^14, exact in BODY_W bits
  function automatic logic signed [BODY_W-1:0] body_field(
    input logic signed [16:0] s,
    input logic [15:0]        g,
    input logic signed [15:0] o
  );
    logic signed [BODY_W-1:0] se;
    logic signed [BODY_W-1:0] ge;
    logic signed [BODY_W-1:0] oe;
    se = s;
    ge = {1'b0, g};
    oe = o;
    return se * ge + (oe <<< 14);
  endfunction

  // Y and Z are negated; -(-32768) stays +32768 in 17 bits
  assign sx   = in_raw_x;
  assign ry_e = in_raw_y;
  assign rz_e = in_raw_z;
  assign sy   = -ry_e;
  assign sz   = -rz_e;

  // Body field computed on entry, then delayed to meet the CORDIC outputs
  always_ff @(posedge clk) begin
    bx_dly_r[0] <= body_field(sx, gain_x_r, offset_x_r);
    by_dly_r[0] <= body_field(sy, gain_y_r, offset_y_r);
    bz_dly_r[0] <= body_field(sz, gain_z_r, offset_z_r);
    for (int k = 1; k < CORDIC_LAT; k++) begin
      bx_dly_r[k] <= bx_dly_r[k-1];
      by_dly_r[k] <= by_dly_r[k-1];
      bz_dly_r[k] <= bz_dly_r[k-1];
    end
  end

  // sin/cos of roll and pitch, side by side
  thc_cordic u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .angle     (in_roll_angle),
    .out_valid (roll_v),
    .sin_q14   (sr),
    .cos_q14   (cr)
  );

  thc_cordic u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .angle     (in_pitch_angle),
    .out_valid (pitch_v),
    .sin_q14   (sp),
    .cos_q14   (cp)
  );

  // Rotation into the horizontal plane, magnitudes, shift, sum of squares
  thc_tilt u_tilt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (roll_v && pitch_v),
    .bx        (bx_dly_r[CORDIC_LAT-1]),
    .by        (by_dly_r[CORDIC_LAT-1]),
    .bz        (bz_dly_r[CORDIC_LAT-1]),
    .sr        (sr),
    .cr        (cr),
    .sp        (sp),
    .cp        (cp),
    .out_valid (tilt_v),
    .sumsq     (sumsq),
    .side_out  (tilt_side)
  );

  // Horizontal magnitude h
  thc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tilt_v),
    .n         (sumsq),
    .side_in   (tilt_side),
    .out_valid (root_v),
    .root      (root),
    .side_out  (root_side)
  );

  // Rounded a / h in Q14 for both components
  thc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_v),
    .h         (root),
    .side_in   (root_side),
    .out_valid (div_v),
    .qx        (qx),
    .qy        (qy),
    .flags_out (div_flags)
  );

  // Clamp to one, apply signs, force zero on an empty horizontal field
  assign hx_c = (qx > QUOT_W'(ONE_Q14)) ? QUOT_W'(ONE_Q14) : qx;
  assign hy_c = (qy > QUOT_W'(ONE_Q14)) ? QUOT_W'(ONE_Q14) : qy;
  assign hx_s = signed'(16'(hx_c));
  assign hy_s = signed'(16'(hy_c));

  always_ff @(posedge clk) begin
    if (div_flags.zero) begin
      heading_x_r <= '0;
      heading_y_r <= '0;
    end else begin
      heading_x_r <= div_flags.neg_x ? -hx_s : hx_s;
      heading_y_r <= div_flags.pos_y ? -hy_s : hy_s;
    end
    zero_field_r <= div_flags.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_v;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_heading_x  = heading_x_r;
  assign out_heading_y  = heading_y_r;
  assign out_zero_field = zero_field_r;

  // Every accepted word comes out on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOTAL_LAT out_valid)
    else $error("result strobe missing after accepted word");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_field) |-> (out_heading_x == 16'sd0 && out_heading_y == 16'sd0))
    else $error("zero field flagged with non-zero heading");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_x <= 16'sd16384 && out_heading_x >= -16'sd16384 &&
                   out_heading_y <= 16'sd16384 && out_heading_y >= -16'sd16384))
    else $error("heading component beyond unit range");

endmodule

`default_nettype wire

@@ sv/thc_cordic.sv @@
// Pipelined CORDIC sine and cosine of a binary angle, Q14 results.
// Depends on thc_pkg.
`default_nettype none

module thc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);
  import thc_pkg::*;

  logic signed [16:0]     ang_e;
  logic signed [16:0]     ang_fold;
  logic                   flip;
  logic signed [XY_W-1:0] x_r    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] y_r    [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_r    [0:CORDIC_STAGES];
  logic                   flip_r [0:CORDIC_STAGES];
  logic                   vld_r  [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] xf;
  logic signed [XY_W-1:0] yf;
  logic                   out_valid_r;
  logic signed [15:0]     sin_r;
  logic signed [15:0]     cos_r;

  function automatic logic signed [15:0] round_q14(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] ve;
    logic signed [XY_W:0] t;
    logic signed [15:0]   r;
    ve = v;
    t  = (ve + (XY_W+1)'(32768)) >>> 16;
    if (t > (XY_W+1)'(16384)) begin
      r = 16'sd16384;
    end else if (t < -(XY_W+1)'(16384)) begin
      r = -16'sd16384;
    end else begin
      r = 16'(t);
    end
    return r;
  endfunction

  // fold into [-pi/2, pi/2], negate at the end
  assign ang_e = angle;
  always_comb begin
    ang_fold = ang_e;
    flip     = 1'b0;
    if (ang_e > 17'sd16384) begin
      ang_fold = ang_e - 17'sd32768;
      flip     = 1'b1;
    end else if (ang_e < -17'sd16384) begin
      ang_fold = ang_e + 17'sd32768;
      flip     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_K;
    y_r[0]    <= '0;
    z_r[0]    <= Z_W'(ang_fold) <<< 8;
    flip_r[0] <= flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!z_r[i][Z_W-1]) begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - atan_lut(i);
      end else begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + atan_lut(i);
      end
      flip_r[i+1] <= flip_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign xf = flip_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
  assign yf = flip_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    cos_r <= round_q14(xf);
    sin_r <= round_q14(yf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[CORDIC_STAGES];
    end
  end

  assign out_valid = out_valid_r;
  assign sin_q14   = sin_r;
  assign cos_q14   = cos_r;

endmodule

`default_nettype wire

@@ sv/thc_tilt.sv @@
// Tilt rotation, magnitudes, common normalising shift and sum of squares.
// Depends on thc_pkg.
`default_nettype none

module thc_tilt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [thc_pkg::BODY_W-1:0] bx,
  input  logic signed [thc_pkg::BODY_W-1:0] by,
  input  logic signed [thc_pkg::BODY_W-1:0] bz,
  input  logic signed [15:0]                sr,
  input  logic signed [15:0]                cr,
  input  logic signed [15:0]                sp,
  input  logic signed [15:0]                cp,
  output logic                              out_valid,
  output logic [thc_pkg::SUM_W-1:0]         sumsq,
  output thc_pkg::side_t                    side_out
);
  import thc_pkg::*;

  // T1: products with one trig term
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_zc_r, p_yc_r, p_zs_r;
  logic signed [15:0]       sp1_r;
  // T2: second products
  logic signed [MX_W-1:0]   pxc_e, pyc_e, pzs_e;
  logic signed [MX_W-1:0]   xa_r, t_y_r, t_z_r, my2_r;
  // T3: sums
  logic signed [MX_W-1:0]   mx_r, my3_r;
  // T4: magnitudes
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic [MAG_W-1:0]         ax4_r, ay4_r;
  flags_t                   fl4_r;
  // N1, N2: shift
  logic [MAG_W-1:0]         ax_a, ay_a, ax_b, ay_b;
  logic [MAG_W-1:0]         ax5_r, ay5_r;
  flags_t                   fl5_r;
  side_t                    side6_r, side7_r, side8_r;
  // S1, S2
  logic [2*NORM_W-1:0]      sq_x_r, sq_y_r;
  logic [SUM_W-1:0]         sum_r;
  logic [TILT_LAT-1:0]      vld_r;

  always_ff @(posedge clk) begin
    p_xc_r <= bx * cp;
    p_ys_r <= by * sr;
    p_zc_r <= bz * cr;
    p_yc_r <= by * cr;
    p_zs_r <= bz * sr;
    sp1_r  <= sp;
  end

  assign pxc_e = p_xc_r;
  assign pyc_e = p_yc_r;
  assign pzs_e = p_zs_r;

  always_ff @(posedge clk) begin
    xa_r  <= pxc_e <<< 14;
    t_y_r <= p_ys_r * sp1_r;
    t_z_r <= p_zc_r * sp1_r;
    my2_r <= (pyc_e - pzs_e) <<< 14;
  end

  always_ff @(posedge clk) begin
    mx_r  <= xa_r + t_y_r + t_z_r;
    my3_r <= my2_r;
  end

  assign mag_x = mx_r[MX_W-1] ? MAG_W'(-mx_r) : MAG_W'(mx_r);
  assign mag_y = my3_r[MX_W-1] ? MAG_W'(-my3_r) : MAG_W'(my3_r);

  always_ff @(posedge clk) begin
    ax4_r       <= mag_x;
    ay4_r       <= mag_y;
    fl4_r.neg_x <= mx_r[MX_W-1];
    fl4_r.pos_y <= !my3_r[MX_W-1] && (my3_r != '0);
    fl4_r.zero  <= (mx_r == '0) && (my3_r == '0);
  end

  // shift both right until they fit NORM_W bits; 32/16/8 then 4/2/1
  always_comb begin
    ax_a = ax4_r;
    ay_a = ay4_r;
    for (int k = 5; k >= 3; k--) begin
      if (((ax_a | ay_a) >> (NORM_W - 1 + (1 << k))) != '0) begin
        ax_a = ax_a >> (1 << k);
        ay_a = ay_a >> (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    ax5_r <= ax_a;
    ay5_r <= ay_a;
    fl5_r <= fl4_r;
  end

  always_comb begin
    ax_b = ax5_r;
    ay_b = ay5_r;
    for (int k = 2; k >= 0; k--) begin
      if (((ax_b | ay_b) >> (NORM_W - 1 + (1 << k))) != '0) begin
        ax_b = ax_b >> (1 << k);
        ay_b = ay_b >> (1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    side6_r.ax    <= ax_b[NORM_W-1:0];
    side6_r.ay    <= ay_b[NORM_W-1:0];
    side6_r.flags <= fl5_r;
  end

  always_ff @(posedge clk) begin
    sq_x_r  <= side6_r.ax * side6_r.ax;
    sq_y_r  <= side6_r.ay * side6_r.ay;
    side7_r <= side6_r;
  end

  always_ff @(posedge clk) begin
    sum_r   <= SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
    side8_r <= side7_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TILT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[TILT_LAT-1];
  assign sumsq     = sum_r;
  assign side_out  = side8_r;

endmodule

`default_nettype wire

@@ sv/thc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on thc_pkg.
`default_nettype none

module thc_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [thc_pkg::SUM_W-1:0]  n,
  input  thc_pkg::side_t             side_in,
  output logic                       out_valid,
  output logic [thc_pkg::ROOT_W-1:0] root,
  output thc_pkg::side_t             side_out
);
  import thc_pkg::*;

  logic [SUM_W-1:0] rem_r  [0:SQRT_STAGES-1];
  logic [SUM_W-1:0] res_r  [0:SQRT_STAGES];
  side_t            side_r [0:SQRT_STAGES];
  logic             vld_r  [0:SQRT_STAGES];

  assign rem_r[0]  = n;
  assign res_r[0]  = '0;
  assign side_r[0] = side_in;
  assign vld_r[0]  = in_valid;

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * (SQRT_STAGES - 1 - i));
    logic [SUM_W-1:0] trial;
    logic             take;
    assign trial = res_r[i] + STEP_BIT;
    assign take  = rem_r[i] >= trial;

    always_ff @(posedge clk) begin
      res_r[i+1]  <= take ? ((res_r[i] >> 1) + STEP_BIT) : (res_r[i] >> 1);
      side_r[i+1] <= side_r[i];
    end

    if (i < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[i+1] <= take ? (rem_r[i] - trial) : rem_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES];
  assign root      = res_r[SQRT_STAGES][ROOT_W-1:0];
  assign side_out  = side_r[SQRT_STAGES];

endmodule

`default_nettype wire

@@ sv/thc_div.sv @@
// Two-lane pipelined restoring divider: (a * 2^14 + h/2) / h for x and y.
// Depends on thc_pkg.
`default_nettype none

module thc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [thc_pkg::ROOT_W-1:0] h,
  input  thc_pkg::side_t             side_in,
  output logic                       out_valid,
  output logic [thc_pkg::QUOT_W-1:0] qx,
  output logic [thc_pkg::QUOT_W-1:0] qy,
  output thc_pkg::flags_t            flags_out
);
  import thc_pkg::*;

  logic [NUM_W-1:0]  rx_r  [0:DIV_STAGES-1];
  logic [NUM_W-1:0]  ry_r  [0:DIV_STAGES-1];
  logic [ROOT_W-1:0] h_r   [0:DIV_STAGES-1];
  logic [QUOT_W-1:0] qx_r  [0:DIV_STAGES];
  logic [QUOT_W-1:0] qy_r  [0:DIV_STAGES];
  flags_t            fl_r  [0:DIV_STAGES];
  logic              vld_r [0:DIV_STAGES];

  // numerator set-up
  always_ff @(posedge clk) begin
    rx_r[0] <= (NUM_W'(side_in.ax) << 14) + NUM_W'(h >> 1);
    ry_r[0] <= (NUM_W'(side_in.ay) << 14) + NUM_W'(h >> 1);
    h_r[0]  <= h;
    qx_r[0] <= '0;
    qy_r[0] <= '0;
    fl_r[0] <= side_in.flags;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    localparam int QB = DIV_STAGES - 1 - i;
    logic [NUM_W-1:0] dv;
    logic             tx;
    logic             ty;
    assign dv = NUM_W'(h_r[i]) << QB;
    assign tx = rx_r[i] >= dv;
    assign ty = ry_r[i] >= dv;

    always_ff @(posedge clk) begin
      qx_r[i+1] <= tx ? (qx_r[i] | (QUOT_W'(1) << QB)) : qx_r[i];
      qy_r[i+1] <= ty ? (qy_r[i] | (QUOT_W'(1) << QB)) : qy_r[i];
      fl_r[i+1] <= fl_r[i];
    end

    if (i < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rx_r[i+1] <= tx ? (rx_r[i] - dv) : rx_r[i];
        ry_r[i+1] <= ty ? (ry_r[i] - dv) : ry_r[i];
        h_r[i+1]  <= h_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES];
  assign qx        = qx_r[DIV_STAGES];
  assign qy        = qy_r[DIV_STAGES];
  assign flags_out = fl_r[DIV_STAGES];

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for tilt_compensated_heading_unit: sample words are queued,
// driven with random gaps, predicted in fixed point and checked against results.
// Depends on thc_pkg and the unit under test only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import thc_pkg::*;

  // one sample word; drain_first makes the driver wait for an empty pipe
  typedef struct {
    logic signed [15:0] raw_x, raw_y, raw_z, roll, pitch;
    bit                 drain_first;
  } sample_t;

  typedef struct {
    logic signed [15:0] hx, hy;
    logic               zero;
  } heading_t;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;  // not a register: write ignored
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam longint     ONE        = 16384;
  localparam longint     CORDIC_GAIN = 652032874;

  logic clk, rst_n;
  logic start, busy, out_valid, out_zero_field, cfg_valid, cfg_ready;
  logic signed [15:0] in_raw_x, in_raw_y, in_raw_z, in_roll_angle, in_pitch_angle;
  logic signed [15:0] out_heading_x, out_heading_y;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  sample_t  pending_samples[$];
  heading_t expected_headings[$];
  int       fail_count;
  int       send_idle_pct;

  // calibration copy held by the bench
  logic [15:0]        cal_gain[3];
  logic signed [15:0] cal_offset[3];

  tilt_compensated_heading_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .out_valid(out_valid), .out_heading_x(out_heading_x),
    .out_heading_y(out_heading_y), .out_zero_field(out_zero_field),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 16-step CORDIC on a binary angle, rounded half up to Q14 and clamped
  task automatic trig_q14(input longint ang, output longint sn, output longint cs);
    longint x, y, z, t, r;
    bit     flip;
    flip = 0;
    if (ang > 16384) begin
      ang -= 32768; flip = 1;
    end else if (ang < -16384) begin
      ang += 32768; flip = 1;
    end
    x = CORDIC_GAIN; y = 0; z = ang * 256;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_lut(i));
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_lut(i));
      end
      x = t;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    r = (x + 32768) >>> 16;
    cs = (r > ONE) ? ONE : (r < -ONE) ? -ONE : r;
    r = (y + 32768) >>> 16;
    sn = (r > ONE) ? ONE : (r < -ONE) ? -ONE : r;
  endtask

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic predict_heading(input sample_t s, output heading_t h);
    longint bx, by, bz, sr, cr, sp, cp, mx, my;
    logic [63:0] ax, ay, root, qx, qy;
    bx = longint'(s.raw_x) * longint'(cal_gain[0]) + longint'(cal_offset[0]) * ONE;
    by = -longint'(s.raw_y) * longint'(cal_gain[1]) + longint'(cal_offset[1]) * ONE;
    bz = -longint'(s.raw_z) * longint'(cal_gain[2]) + longint'(cal_offset[2]) * ONE;
    trig_q14(longint'(s.roll), sr, cr);
    trig_q14(longint'(s.pitch), sp, cp);
    mx = bx * cp * ONE + by * sr * sp + bz * cr * sp;
    my = (by * cr - bz * sr) * ONE;
    if (mx == 0 && my == 0) begin
      h.hx = 0; h.hy = 0; h.zero = 1'b1;
      return;
    end
    ax = (mx < 0) ? -mx : mx;
    ay = (my < 0) ? -my : my;
    // common truncating shift until both fit the root stage
    while ((ax | ay) >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1;
    end
    root = floor_sqrt(ax * ax + ay * ay);
    qx = (ax * ONE + root / 2) / root;
    qy = (ay * ONE + root / 2) / root;
    if (qx > ONE) qx = ONE;
    if (qy > ONE) qy = ONE;
    h.hx = (mx < 0) ? -qx[15:0] : qx[15:0];
    h.hy = (my > 0) ? -qy[15:0] : qy[15:0];
    h.zero = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the oldest pending word, holds start until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    heading_t h;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_heading(pending_samples[0], h);
        expected_headings.push_back(h);
        void'(pending_samples.pop_front());
      end
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          (!pending_samples[0].drain_first || expected_headings.size() == 0)) begin
        start          <= 1'b1;
        in_raw_x       <= pending_samples[0].raw_x;
        in_raw_y       <= pending_samples[0].raw_y;
        in_raw_z       <= pending_samples[0].raw_z;
        in_roll_angle  <= pending_samples[0].roll;
        in_pitch_angle <= pending_samples[0].pitch;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    heading_t e;
    if (rst_n && out_valid) begin
      if (expected_headings.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        e = expected_headings.pop_front();
        if (out_heading_x !== e.hx) report("heading_x", out_heading_x, e.hx);
        if (out_heading_y !== e.hy) report("heading_y", out_heading_y, e.hy);
        if (out_zero_field !== e.zero) report("zero_field", out_zero_field, e.zero);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIN_X:   cal_gain[0] = val;
      REG_GAIN_Y:   cal_gain[1] = val;
      REG_GAIN_Z:   cal_gain[2] = val;
      REG_OFFSET_X: cal_offset[0] = val;
      REG_OFFSET_Y: cal_offset[1] = val;
      REG_OFFSET_Z: cal_offset[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_cal(input logic [15:0] gx, gy, gz, ox, oy, oz);
    write_reg(REG_GAIN_X, gx);   write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_Z, gz);   write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy); write_reg(REG_OFFSET_Z, oz);
  endtask

  // pipeline empty and the full latency waited out
  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_headings.size() != 0)
      @(posedge clk);
    repeat (TOTAL_LAT + 8) @(posedge clk);
  endtask

  task automatic push_sample(input logic [15:0] x, y, z, r, p, input bit drain = 0);
    sample_t s;
    s.raw_x = x; s.raw_y = y; s.raw_z = z; s.roll = r; s.pitch = p;
    s.drain_first = drain;
    pending_samples.push_back(s);
  endtask

  // mostly full-range words; some small fields and some angle extremes
  task automatic push_random(input int n);
    logic [15:0] f[5];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 5; k++) begin
        case ($urandom_range(9))
          0:       f[k] = 16'($urandom_range(15) - 8);
          1:       f[k] = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
          2:       f[k] = ($urandom_range(1) != 0) ? 16'h4000 : 16'hc000;
          default: f[k] = 16'($urandom);
        endcase
      end
      push_sample(f[0], f[1], f[2], f[3], f[4], $urandom_range(199) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_raw_x = '0; in_raw_y = '0; in_raw_z = '0; in_roll_angle = '0; in_pitch_angle = '0;
    fail_count = 0; send_idle_pct = 22;
    cal_gain = '{16'd16384, 16'd16384, 16'd16384};
    cal_offset = '{16'sd0, 16'sd0, 16'sd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset calibration
    push_sample(0, 0, 0, 0, 0);                               // zero horizontal field
    push_sample(16'h7fff, 16'h7fff, 16'h7fff, 0, 0);
    push_sample(16'h8000, 16'h8000, 16'h8000, 0, 0);          // negating -32768
    push_sample(0, 16'h8000, 0, 16'h8000, 16'h8000);
    push_sample(100, 200, 300, 16'h7fff, 16'h7fff);
    push_sample(100, 200, 300, 16'h4000, 16'hc000);           // quarter turns
    push_sample(100, 200, 300, 16'h4001, 16'hbfff);           // just past a quarter turn
    push_sample(0, 0, 1000, 16'h4000, 0);
    push_sample(1, 0, 0, 0, 16'h4000);                        // x fully tilted away
    push_sample(16'hffff, 1, 16'hffff, 16'h2000, 16'he000, 1);
    push_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    push_random(150);

    // extreme gains and offsets, nothing may saturate
    wait_idle(); send_idle_pct = 22;
    set_cal(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff);
    push_sample(16'h7fff, 16'h8000, 16'h8000, 0, 0);
    push_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h1234, 16'h8000);
    push_random(150);

    wait_idle();
    set_cal(16'hffff, 16'h0, 16'hffff, 16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    push_random(150);

    // zero gains, zero offsets: every word a zero field
    wait_idle(); send_idle_pct = 55;
    set_cal(0, 0, 0, 0, 0, 0);
    push_random(40);

    // offsets alone drive the field; unused register indexes must be ignored
    wait_idle();
    write_reg(REG_OFFSET_X, 16'h0001);
    write_reg(REG_SPARE_6, 16'hffff);
    write_reg(REG_SPARE_7, 16'h1234);
    push_sample(0, 0, 0, 0, 0);
    push_random(160);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      send_idle_pct = (ph < 2) ? 55 : 0;
      set_cal(16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
      push_sample(16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1);
      push_random(120);
    end

    // back to unity gains
    wait_idle();
    set_cal(16'd16384, 16'd16384, 16'd16384, 0, 0, 0);
    push_random(120);

    while (pending_samples.size() != 0 || expected_headings.size() != 0)
      @(posedge clk);
    repeat (TOTAL_LAT + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
